### src/qpvo_pkg.sv
// Shared types, constants and saturating helpers for the quadrature PI velocity observer.
package qpvo_pkg;

	typedef enum logic [1:0] {
		CMD_A_EDGE = 2'd0,
		CMD_B_EDGE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MM_PER_COUNT = 2'd0,
		REG_KP_GAIN      = 2'd1,
		REG_KI_GAIN      = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_EDGE,
		OP_CLEAR,
		OP_START,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_MUL_RES,
		OP_DT_ADJ,
		OP_POS_ADD,
		OP_ERR,
		OP_INT_ADD,
		OP_VEL_ADD,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [2:0] {
		SRC_X_RECIP,
		SRC_DT_EST,
		SRC_VEL_DT,
		SRC_CNT_MM,
		SRC_ERR_KI,
		SRC_PROD_DT,
		SRC_ERR_KP
	} mul_src_t;

	typedef struct packed {
		dp_op_t   op;
		mul_src_t src;
	} dp_cmd_t;

	typedef struct packed {
		logic lo;
		logic hi;
	} mul_ctl_t;

	localparam logic [31:0] MM_PER_COUNT_RESET = 32'd65536;

	// dt = floor(us * 1024 / 15625); reciprocal floor(2^30 / 15625), off by at most one
	localparam int unsigned  DT_SHIFT = 30;
	localparam logic [16:0]  DT_RECIP = 17'd68719;
	localparam logic [13:0]  DT_DIV   = 14'd15625;

	localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;

	function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
		input logic signed [47:0] b);
		logic [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) begin
			sat_add48 = s[48] ? SAT_MIN : SAT_MAX;
		end else begin
			sat_add48 = s[47:0];
		end
	endfunction

	function automatic logic signed [47:0] sat_sub48(input logic signed [47:0] a,
		input logic signed [47:0] b);
		logic [48:0] s;
		s = {a[47], a} - {b[47], b};
		if (s[48] != s[47]) begin
			sat_sub48 = s[48] ? SAT_MIN : SAT_MAX;
		end else begin
			sat_sub48 = s[47:0];
		end
	endfunction

endpackage

### src/quadrature_pi_velocity_observer.sv
// Top level: quadrature edge counter with PI position and velocity observer.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    cmd, pin_level, elapsed_us
//   out      source     out_valid / out_ready  edge_count, position_estimate, velocity_estimate
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Edge and clear items update state at the transfer and go straight to the publish step.
// Update tick: a reciprocal dt division (two products) and five observer products
// through the one shared 48x32 multiplier (two 24x32 passes each),
// plus saturating adds and publish.
// One item in work at a time; the next item transfers while the result waits in its register.
// A stalled output holds the controller in its publish step; reset clears state at once.
module quadrature_pi_velocity_observer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic                pin_level,
	input  logic [19:0]         elapsed_us,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  edge_count,
	output logic signed [47:0]  position_estimate,
	output logic signed [47:0]  velocity_estimate,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import qpvo_pkg::*;

	dp_cmd_t dcmd;

	qpvo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.dcmd      (dcmd)
	);

	qpvo_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.dcmd              (dcmd),
		.cmd               (cmd),
		.pin_level         (pin_level),
		.elapsed_us        (elapsed_us),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.edge_count        (edge_count),
		.position_estimate (position_estimate),
		.velocity_estimate (velocity_estimate)
	);

	// one item in work: a transfer closes the input until its result is published
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened while an item is in work");

	// a new result only follows a step in which the input was closed
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

	// a clear item with a free result register publishes all-zero state
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_CLEAR && (!out_valid || out_ready)
		|=> ##1 (out_valid && edge_count == 32'sd0 && position_estimate == 48'sd0
			&& velocity_estimate == 48'sd0))
		else $error("clear item did not publish cleared state");

endmodule

### src/qpvo_mul.sv
// Shared 48x32 magnitude multiplier in two 24x32 halves, with Q.16 shift and saturation.
module qpvo_mul (
	input  logic                     clk,
	input  qpvo_pkg::mul_ctl_t       ctl,
	input  logic [47:0]              mag,
	input  logic [31:0]              factor,
	input  logic                     neg,
	input  logic                     shr,
	output logic [79:0]              raw,
	output logic signed [47:0]       result
);
	import qpvo_pkg::*;

	logic [79:0] acc_q;
	logic [23:0] mhi_q;
	logic [31:0] fac_q;
	logic        neg_q;
	logic        shr_q;
	logic [55:0] lo_prod;
	logic [55:0] hi_prod;
	logic [63:0] r64;
	logic        big;

	assign lo_prod = mag[23:0] * factor;
	assign hi_prod = mhi_q * fac_q;

	always_ff @(posedge clk) begin
		if (ctl.lo) begin
			acc_q <= {24'd0, lo_prod};
			mhi_q <= mag[47:24];
			fac_q <= factor;
			neg_q <= neg;
			shr_q <= shr;
		end else if (ctl.hi) begin
			acc_q <= acc_q + {hi_prod, 24'd0};
		end
	end

	assign raw = acc_q;

	always_comb begin
		r64 = shr_q ? acc_q[79:16] : acc_q[63:0];
		big = |r64[63:47];
		if (neg_q) begin
			result = big ? SAT_MIN : 48'd0 - r64[47:0];
		end else begin
			result = big ? SAT_MAX : r64[47:0];
		end
	end

endmodule

### src/qpvo_dp.sv
// Datapath: configuration, encoder count, observer state, multiplier operands and result register.
module qpvo_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qpvo_pkg::dp_cmd_t    dcmd,
	input  logic [1:0]           cmd,
	input  logic                 pin_level,
	input  logic [19:0]          elapsed_us,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic signed [31:0]   edge_count,
	output logic signed [47:0]   position_estimate,
	output logic signed [47:0]   velocity_estimate
);
	import qpvo_pkg::*;

	logic [31:0]        mm_q;
	logic [31:0]        kp_q;
	logic [31:0]        ki_q;
	logic               level_a_q;
	logic               level_b_q;
	logic signed [31:0] count_q;
	logic signed [47:0] pos_q;
	logic signed [47:0] integ_q;
	logic signed [47:0] vel_q;

	logic [29:0]        x_q;
	logic [16:0]        dt_q;
	logic signed [47:0] prod_q;
	logic signed [47:0] err_q;
	logic signed [31:0] cnt_out_q;
	logic signed [47:0] pos_out_q;
	logic signed [47:0] vel_out_q;

	mul_ctl_t           mctl;
	logic [47:0]        m_mag;
	logic [31:0]        m_fac;
	logic               m_neg;
	logic               m_shr;
	logic [79:0]        m_raw;
	logic signed [47:0] m_res;
	logic [31:0]        cnt_mag;
	logic               step_up;
	logic [30:0]        dt_rem;

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		mag48 = v[47] ? 48'd0 - v : v;
	endfunction

	assign cnt_mag = count_q[31] ? 32'd0 - count_q : count_q;
	assign dt_rem  = {1'b0, x_q} - m_raw[30:0];
	assign step_up = (cmd == CMD_A_EDGE) ? (pin_level != level_b_q) : (pin_level == level_a_q);

	assign mctl.lo = (dcmd.op == OP_MUL_LO);
	assign mctl.hi = (dcmd.op == OP_MUL_HI);

	always_comb begin
		m_mag = '0;
		m_fac = '0;
		m_neg = 1'b0;
		m_shr = 1'b1;
		unique case (dcmd.src)
			SRC_X_RECIP: begin
				m_mag = {18'd0, x_q};
				m_fac = {15'd0, DT_RECIP};
				m_shr = 1'b0;
			end
			SRC_DT_EST: begin
				m_mag = {31'd0, m_raw[DT_SHIFT+16:DT_SHIFT]};
				m_fac = {18'd0, DT_DIV};
				m_shr = 1'b0;
			end
			SRC_VEL_DT: begin
				m_mag = mag48(vel_q);
				m_neg = vel_q[47];
				m_fac = {15'd0, dt_q};
			end
			SRC_CNT_MM: begin
				m_mag = {16'd0, cnt_mag};
				m_neg = count_q[31];
				m_fac = mm_q;
				m_shr = 1'b0;
			end
			SRC_ERR_KI: begin
				m_mag = mag48(err_q);
				m_neg = err_q[47];
				m_fac = ki_q;
			end
			SRC_PROD_DT: begin
				m_mag = mag48(prod_q);
				m_neg = prod_q[47];
				m_fac = {15'd0, dt_q};
			end
			SRC_ERR_KP: begin
				m_mag = mag48(err_q);
				m_neg = err_q[47];
				m_fac = kp_q;
			end
			default: begin
				m_mag = '0;
			end
		endcase
	end

	qpvo_mul u_mul (
		.clk    (clk),
		.ctl    (mctl),
		.mag    (m_mag),
		.factor (m_fac),
		.neg    (m_neg),
		.shr    (m_shr),
		.raw    (m_raw),
		.result (m_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q <= MM_PER_COUNT_RESET;
			kp_q <= '0;
			ki_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MM_PER_COUNT: mm_q <= cfg_data;
				REG_KP_GAIN:      kp_q <= cfg_data;
				REG_KI_GAIN:      ki_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_a_q <= 1'b0;
			level_b_q <= 1'b0;
			count_q   <= '0;
			pos_q     <= '0;
			integ_q   <= '0;
			vel_q     <= '0;
		end else begin
			unique case (dcmd.op)
				OP_EDGE: begin
					if (cmd == CMD_A_EDGE) begin
						level_a_q <= pin_level;
					end else begin
						level_b_q <= pin_level;
					end
					count_q <= count_q + (step_up ? 32'sd1 : -32'sd1);
				end
				OP_CLEAR: begin
					count_q <= '0;
					pos_q   <= '0;
					integ_q <= '0;
					vel_q   <= '0;
				end
				OP_POS_ADD: pos_q   <= sat_add48(pos_q, prod_q);
				OP_INT_ADD: integ_q <= sat_add48(integ_q, prod_q);
				OP_VEL_ADD: vel_q   <= sat_add48(prod_q, integ_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			OP_START: x_q <= {elapsed_us, 10'd0};
			OP_MUL_LO: begin
				// first DT product leaves the quotient estimate in the accumulator
				if (dcmd.src == SRC_DT_EST) begin
					dt_q <= m_raw[DT_SHIFT+16:DT_SHIFT];
				end
			end
			OP_DT_ADJ: begin
				if (dt_rem >= {17'd0, DT_DIV}) begin
					dt_q <= dt_q + 17'd1;
				end
			end
			OP_MUL_RES: prod_q <= m_res;
			OP_ERR:     err_q  <= sat_sub48(prod_q, pos_q);
			OP_PUBLISH: begin
				cnt_out_q <= count_q;
				pos_out_q <= pos_q;
				vel_out_q <= vel_q;
			end
			default: ;
		endcase
	end

	assign edge_count        = cnt_out_q;
	assign position_estimate = pos_out_q;
	assign velocity_estimate = vel_out_q;

endmodule

### src/qpvo_ctrl.sv
// Controller: item acceptance, tick sequencing over the shared multiplier, result handshake.
module qpvo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          cmd,
	input  logic                out_ready,
	output logic                in_ready,
	output logic                out_valid,
	output qpvo_pkg::dp_cmd_t   dcmd
);
	import qpvo_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DTA_LO, S_DTA_HI, S_DTB_LO, S_DTB_HI, S_DT_ADJ,
		S_POS_LO, S_POS_HI, S_POS_RES, S_POS_ADD,
		S_MEAS_LO, S_MEAS_HI, S_MEAS_RES, S_ERR,
		S_KI_LO, S_KI_HI, S_KI_RES,
		S_KIDT_LO, S_KIDT_HI, S_KIDT_RES, S_INT_ADD,
		S_KP_LO, S_KP_HI, S_KP_RES, S_VEL_ADD,
		S_PUB
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   pub_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pub_go    = (state_q == S_PUB) && (!out_valid_q || out_ready);

	always_comb begin
		dcmd.op  = OP_NOP;
		dcmd.src = SRC_X_RECIP;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority if (cmd == CMD_TICK) begin
						dcmd.op = OP_START;
						state_d = S_DTA_LO;
					end else if (cmd == CMD_CLEAR) begin
						dcmd.op = OP_CLEAR;
						state_d = S_PUB;
					end else begin
						dcmd.op = OP_EDGE;
						state_d = S_PUB;
					end
				end
			end
			S_DTA_LO:   begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_X_RECIP; state_d = S_DTA_HI; end
			S_DTA_HI:   begin dcmd.op = OP_MUL_HI; state_d = S_DTB_LO; end
			S_DTB_LO:   begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_DT_EST; state_d = S_DTB_HI; end
			S_DTB_HI:   begin dcmd.op = OP_MUL_HI; state_d = S_DT_ADJ; end
			S_DT_ADJ:   begin dcmd.op = OP_DT_ADJ; state_d = S_POS_LO; end
			S_POS_LO:   begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_VEL_DT; state_d = S_POS_HI; end
			S_POS_HI:   begin dcmd.op = OP_MUL_HI; state_d = S_POS_RES; end
			S_POS_RES:  begin dcmd.op = OP_MUL_RES; state_d = S_POS_ADD; end
			S_POS_ADD:  begin dcmd.op = OP_POS_ADD; state_d = S_MEAS_LO; end
			S_MEAS_LO:  begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_CNT_MM; state_d = S_MEAS_HI; end
			S_MEAS_HI:  begin dcmd.op = OP_MUL_HI; state_d = S_MEAS_RES; end
			S_MEAS_RES: begin dcmd.op = OP_MUL_RES; state_d = S_ERR; end
			S_ERR:      begin dcmd.op = OP_ERR; state_d = S_KI_LO; end
			S_KI_LO:    begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_ERR_KI; state_d = S_KI_HI; end
			S_KI_HI:    begin dcmd.op = OP_MUL_HI; state_d = S_KI_RES; end
			S_KI_RES:   begin dcmd.op = OP_MUL_RES; state_d = S_KIDT_LO; end
			S_KIDT_LO:  begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_PROD_DT; state_d = S_KIDT_HI; end
			S_KIDT_HI:  begin dcmd.op = OP_MUL_HI; state_d = S_KIDT_RES; end
			S_KIDT_RES: begin dcmd.op = OP_MUL_RES; state_d = S_INT_ADD; end
			S_INT_ADD:  begin dcmd.op = OP_INT_ADD; state_d = S_KP_LO; end
			S_KP_LO:    begin dcmd.op = OP_MUL_LO; dcmd.src = SRC_ERR_KP; state_d = S_KP_HI; end
			S_KP_HI:    begin dcmd.op = OP_MUL_HI; state_d = S_KP_RES; end
			S_KP_RES:   begin dcmd.op = OP_MUL_RES; state_d = S_VEL_ADD; end
			S_VEL_ADD:  begin dcmd.op = OP_VEL_ADD; state_d = S_PUB; end
			S_PUB: begin
				// hold until the result register is free
				if (pub_go) begin
					dcmd.op = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pub_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### test/quadrature_pi_velocity_observer_test.sv
// Testbench for the quadrature PI velocity observer: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module quadrature_pi_velocity_observer_test;
	import qpvo_pkg::*;

	typedef struct packed {
		logic [31:0] count;
		logic [47:0] pos;
		logic [47:0] vel;
	} obs_result_t;

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  reg_sel;
		logic [31:0] reg_val;
		cmd_t        op;
		logic        level;
		logic [19:0] us;
		logic        typed;
		obs_result_t want;
	} vec_row_t;

	localparam logic [1:0]  REG_UNUSED    = 2'd3;
	localparam logic [63:0] US_PER_SEC    = 64'd1000000;
	localparam longint      Q_MAX         = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint      Q_MIN         = -64'sh0000_8000_0000_0000;
	localparam int          SETTLE_CYCLES = 32;
	localparam int          LONG_HOLD     = 400;
	localparam int          STALL_LIMIT   = 3000;
	localparam int          PHASES        = 7;
	localparam int          PHASE_ITEMS   = 250;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic        pin_level;
	logic [19:0] elapsed_us;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] edge_count;
	logic signed [47:0] position_estimate;
	logic signed [47:0] velocity_estimate;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	quadrature_pi_velocity_observer u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cmd               (cmd),
		.pin_level         (pin_level),
		.elapsed_us        (elapsed_us),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.edge_count        (edge_count),
		.position_estimate (position_estimate),
		.velocity_estimate (velocity_estimate),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// observer copy: configuration and state
	logic [31:0] mm_model, kp_model, ki_model;
	logic [31:0] count_model;
	logic        chan_a, chan_b;
	longint      pos_model, integ_model, vel_model;

	obs_result_t expected_results[$];
	vec_row_t    directed_rows[$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          tx_quiet, rx_quiet, hold_request, fwd_dir;

	function automatic longint clamp48(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	// Q32.16 times unsigned Q16.16, magnitude truncated, saturated
	function automatic longint scale_q16(input longint a, input logic [31:0] b);
		logic [63:0] mag;
		logic [95:0] prod;
		logic [63:0] r;
		mag = (a < 0) ? -a : a;
		prod = {32'd0, mag} * {64'd0, b};
		r = prod[79:16];
		if (a < 0) return (r >= 64'h0000_8000_0000_0000) ? Q_MIN : -longint'(r);
		return (r > 64'h0000_7FFF_FFFF_FFFF) ? Q_MAX : longint'(r);
	endfunction

	function automatic obs_result_t observer_step(input cmd_t op, input logic lvl,
		input logic [19:0] us);
		logic [63:0] dt;
		longint measured, err;
		obs_result_t res;
		case (op)
			CMD_A_EDGE: begin
				chan_a = lvl;
				count_model += (chan_a != chan_b) ? 32'd1 : 32'hFFFF_FFFF;
			end
			CMD_B_EDGE: begin
				chan_b = lvl;
				count_model += (chan_a == chan_b) ? 32'd1 : 32'hFFFF_FFFF;
			end
			CMD_TICK: begin
				dt = ({44'd0, us} << 16) / US_PER_SEC;
				measured = clamp48(longint'($signed(count_model)) * longint'({32'd0, mm_model}));
				pos_model = clamp48(pos_model + scale_q16(vel_model, dt[31:0]));
				err = clamp48(measured - pos_model);
				integ_model = clamp48(integ_model +
					scale_q16(scale_q16(err, ki_model), dt[31:0]));
				vel_model = clamp48(scale_q16(err, kp_model) + integ_model);
			end
			default: begin
				// levels survive a clear
				count_model = '0;
				pos_model = 0;
				integ_model = 0;
				vel_model = 0;
			end
		endcase
		res.count = count_model;
		res.pos = pos_model[47:0];
		res.vel = vel_model[47:0];
		return res;
	endfunction

	task automatic add_item(input cmd_t op, input logic lvl, input logic [19:0] us);
		vec_row_t row;
		row = '0;
		row.op = op;
		row.level = lvl;
		row.us = us;
		directed_rows.push_back(row);
	endtask

	task automatic add_typed(input cmd_t op, input logic lvl, input logic [19:0] us,
		input logic [31:0] cnt, input logic [47:0] pos, input logic [47:0] vel);
		vec_row_t row;
		row = '0;
		row.op = op;
		row.level = lvl;
		row.us = us;
		row.typed = 1'b1;
		row.want = {cnt, pos, vel};
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
		vec_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_sel = idx;
		row.reg_val = val;
		directed_rows.push_back(row);
	endtask

	task automatic offer_item(input cmd_t op, input logic lvl, input logic [19:0] us,
		input logic typed, input obs_result_t want);
		int gap;
		obs_result_t predicted;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pin_level <= lvl;
		elapsed_us <= us;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = observer_step(op, lvl, us);
		expected_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MM_PER_COUNT: mm_model = val;
			REG_KP_GAIN:      kp_model = val;
			REG_KI_GAIN:      ki_model = val;
			default:          ;
		endcase
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd65536;
			3: return $urandom_range(0, 32'h000F_FFFF);
			4: return $urandom_range(32'h0000_4000, 32'h0100_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input int n_items);
		int sel;
		cmd_t op;
		logic lvl;
		logic [19:0] us;
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(0, 99);
			lvl = 1'($urandom_range(0, 1));
			us = 20'($urandom_range(0, 20'hFFFFF));
			if (sel < 68) begin
				// clean quadrature step, direction reverses now and then
				if ($urandom_range(0, 15) == 0) fwd_dir = !fwd_dir;
				if ((chan_a == chan_b) == fwd_dir) begin
					op = CMD_A_EDGE;
					lvl = !chan_a;
				end else begin
					op = CMD_B_EDGE;
					lvl = !chan_b;
				end
			end else if (sel < 86) begin
				op = CMD_TICK;
				case ($urandom_range(0, 7))
					0: us = 20'($urandom_range(0, 20));
					1: ;
					default: us = 20'($urandom_range(900, 1100));
				endcase
			end else if (sel < 89) begin
				op = CMD_CLEAR;
			end else begin
				// glitch: random channel, random level
				op = $urandom_range(0, 1) ? CMD_B_EDGE : CMD_A_EDGE;
			end
			offer_item(op, lvl, us, 1'b0, '0);
		end
	endtask

	task automatic check_result();
		obs_result_t want;
		if (expected_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: count %h pos %h vel %h",
					edge_count, position_estimate, velocity_estimate);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			if (edge_count !== want.count || position_estimate !== want.pos ||
				velocity_estimate !== want.vel) begin
				if (mismatches < 10)
					$display("mismatch: count %h/%h pos %h/%h vel %h/%h (exp/act)",
						want.count, edge_count, want.pos, position_estimate,
						want.vel, velocity_estimate);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** quadrature_pi_velocity_observer: FAILED **");
			$finish;
		end
	end

	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_result();
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_A_EDGE;
		pin_level = 1'b0;
		elapsed_us = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MM_PER_COUNT;
		cfg_data = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_request = 1'b0;
		fwd_dir = 1'b1;
		mm_model = MM_PER_COUNT_RESET;
		kp_model = '0;
		ki_model = '0;
		count_model = '0;
		chan_a = 1'b0;
		chan_b = 1'b0;
		pos_model = 0;
		integ_model = 0;
		vel_model = 0;

		// one full forward cycle, then two reverse steps, under reset gains
		add_typed(CMD_A_EDGE, 1'b1, 20'd0, 32'd1, 48'd0, 48'd0);
		add_typed(CMD_B_EDGE, 1'b1, 20'hFFFFF, 32'd2, 48'd0, 48'd0);
		add_typed(CMD_A_EDGE, 1'b0, 20'd0, 32'd3, 48'd0, 48'd0);
		add_typed(CMD_B_EDGE, 1'b0, 20'd0, 32'd4, 48'd0, 48'd0);
		add_typed(CMD_B_EDGE, 1'b1, 20'd0, 32'd3, 48'd0, 48'd0);
		add_typed(CMD_A_EDGE, 1'b1, 20'd0, 32'd2, 48'd0, 48'd0);
		add_typed(CMD_TICK, 1'b1, 20'd0, 32'd2, 48'd0, 48'd0);
		add_item(CMD_TICK, 1'b0, 20'd1000);
		add_typed(CMD_CLEAR, 1'b1, 20'hFFFFF, 32'd0, 48'd0, 48'd0);
		// levels kept through the clear: step back below zero
		add_typed(CMD_B_EDGE, 1'b0, 20'd0, 32'hFFFF_FFFF, 48'd0, 48'd0);
		add_cfg(REG_KP_GAIN, 32'd65536);
		add_typed(CMD_TICK, 1'b0, 20'd0, 32'hFFFF_FFFF, 48'd0, -48'sd65536);
		add_typed(CMD_TICK, 1'b0, 20'd1000000, 32'hFFFF_FFFF, -48'sd65536, 48'd0);
		add_typed(CMD_TICK, 1'b0, 20'd15, 32'hFFFF_FFFF, -48'sd65536, 48'd0);
		add_cfg(REG_KI_GAIN, 32'd65536);
		add_item(CMD_A_EDGE, 1'b0, 20'd0);
		add_item(CMD_TICK, 1'b0, 20'hFFFFF);
		add_item(CMD_TICK, 1'b1, 20'd500000);
		add_cfg(REG_MM_PER_COUNT, 32'hFFFF_FFFF);
		add_cfg(REG_KP_GAIN, 32'hFFFF_FFFF);
		add_cfg(REG_KI_GAIN, 32'hFFFF_FFFF);
		add_item(CMD_TICK, 1'b0, 20'hFFFFF);
		add_item(CMD_TICK, 1'b0, 20'hFFFFF);
		add_item(CMD_TICK, 1'b1, 20'hFFFFF);
		add_typed(CMD_CLEAR, 1'b0, 20'd0, 32'd0, 48'd0, 48'd0);
		add_cfg(REG_UNUSED, 32'hA5A5_5A5A);
		add_item(CMD_B_EDGE, 1'b1, 20'd0);
		add_item(CMD_TICK, 1'b0, 20'd1000);
		add_cfg(REG_MM_PER_COUNT, 32'd0);
		add_item(CMD_TICK, 1'b0, 20'd1000000);
		add_item(CMD_A_EDGE, 1'b0, 20'hFFFFF);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
			end else begin
				offer_item(directed_rows[i].op, directed_rows[i].level, directed_rows[i].us,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(REG_MM_PER_COUNT, 32'hFFFF_FFFF);
					write_reg(REG_KP_GAIN, 32'hFFFF_FFFF);
					write_reg(REG_KI_GAIN, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_MM_PER_COUNT, 32'd0);
					write_reg(REG_KP_GAIN, 32'd0);
					write_reg(REG_KI_GAIN, 32'd0);
				end
				default: begin
					write_reg(REG_MM_PER_COUNT, pick_gain());
					write_reg(REG_KP_GAIN, pick_gain());
					write_reg(REG_KI_GAIN, pick_gain());
				end
			endcase
			write_reg(REG_UNUSED, $urandom);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			// hold the result side off so the input backs up
			if (p == 2 || p == 5) begin
				tx_quiet = 1'b1;
				hold_request = 1'b1;
			end
			run_phase(PHASE_ITEMS);
		end

		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("** quadrature_pi_velocity_observer: PASSED **");
		end else begin
			$display("** quadrature_pi_velocity_observer: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
src/qpvo_pkg.sv
src/qpvo_mul.sv
src/qpvo_dp.sv
src/qpvo_ctrl.sv
src/quadrature_pi_velocity_observer.sv
test/quadrature_pi_velocity_observer_test.sv
